[rtl/kkme_pkg.sv]
// Package for the keycode to keysym map engine: codes, result layout, constant tables.
package kkme_pkg;

  // Request kinds carried on the input tuser
  typedef enum logic [1:0] {
    K_INSTALL = 2'd0,
    K_LOOKUP  = 2'd1,
    K_REVERSE = 2'd2,
    K_RESTORE = 2'd3
  } kind_t;

  // Result status codes
  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_IGNORED   = 2'd1;
  localparam logic [1:0] ST_EXHAUSTED = 2'd2;
  localparam logic [1:0] ST_ALLOC     = 2'd3;

  localparam int unsigned SYM_W  = 29;
  localparam int unsigned CODE_W = 8;

  // Result item, last member in the lowest bits (matches m_tdata packing)
  typedef struct packed {
    logic [1:0]        status;
    logic [7:0]        text_byte;
    logic              has_text;
    logic [CODE_W-1:0] keycode_out;
    logic [SYM_W-1:0]  keysym_out;
  } res_t;

  // One-byte text translation: bit 8 set when a byte exists
  function automatic logic [8:0] translate_sym(logic [SYM_W-1:0] ks);
    logic [8:0] r;
    r = 9'd0;
    if ((ks >= 29'h20 && ks <= 29'h7e) || (ks >= 29'ha0 && ks <= 29'hff)) begin
      r = {1'b1, ks[7:0]};
    end else begin
      case (ks)
        29'hff0d: r = {1'b1, 8'h0d};
        29'hff09: r = {1'b1, 8'h09};
        29'hff08: r = {1'b1, 8'h08};
        29'hff1b: r = {1'b1, 8'h1b};
        29'hffff: r = {1'b1, 8'h7f};
        default:  r = 9'd0;
      endcase
    end
    return r;
  endfunction

  // US QWERTY default map
  function automatic logic [SYM_W-1:0] default_keysym(logic [7:0] code);
    logic [SYM_W-1:0] s;
    case (code)
      8'd9:   s = 29'hff1b;
      8'd10:  s = 29'h31;
      8'd11:  s = 29'h32;
      8'd12:  s = 29'h33;
      8'd13:  s = 29'h34;
      8'd14:  s = 29'h35;
      8'd15:  s = 29'h36;
      8'd16:  s = 29'h37;
      8'd17:  s = 29'h38;
      8'd18:  s = 29'h39;
      8'd19:  s = 29'h30;
      8'd20:  s = 29'h2d;
      8'd21:  s = 29'h3d;
      8'd22:  s = 29'hff08;
      8'd23:  s = 29'hff09;
      8'd24:  s = 29'h71;
      8'd25:  s = 29'h77;
      8'd26:  s = 29'h65;
      8'd27:  s = 29'h72;
      8'd28:  s = 29'h74;
      8'd29:  s = 29'h79;
      8'd30:  s = 29'h75;
      8'd31:  s = 29'h69;
      8'd32:  s = 29'h6f;
      8'd33:  s = 29'h70;
      8'd34:  s = 29'h5b;
      8'd35:  s = 29'h5d;
      8'd36:  s = 29'hff0d;
      8'd37:  s = 29'hffe3;
      8'd38:  s = 29'h61;
      8'd39:  s = 29'h73;
      8'd40:  s = 29'h64;
      8'd41:  s = 29'h66;
      8'd42:  s = 29'h67;
      8'd43:  s = 29'h68;
      8'd44:  s = 29'h6a;
      8'd45:  s = 29'h6b;
      8'd46:  s = 29'h6c;
      8'd47:  s = 29'h3b;
      8'd48:  s = 29'h27;
      8'd49:  s = 29'h60;
      8'd50:  s = 29'hffe1;
      8'd51:  s = 29'h5c;
      8'd52:  s = 29'h7a;
      8'd53:  s = 29'h78;
      8'd54:  s = 29'h63;
      8'd55:  s = 29'h76;
      8'd56:  s = 29'h62;
      8'd57:  s = 29'h6e;
      8'd58:  s = 29'h6d;
      8'd59:  s = 29'h2c;
      8'd60:  s = 29'h2e;
      8'd61:  s = 29'h2f;
      8'd62:  s = 29'hffe2;
      8'd63:  s = 29'hffaa;
      8'd64:  s = 29'hffe9;
      8'd65:  s = 29'h20;
      8'd66:  s = 29'hffe5;
      8'd67:  s = 29'hffbe;
      8'd68:  s = 29'hffbf;
      8'd69:  s = 29'hffc0;
      8'd70:  s = 29'hffc1;
      8'd71:  s = 29'hffc2;
      8'd72:  s = 29'hffc3;
      8'd73:  s = 29'hffc4;
      8'd74:  s = 29'hffc5;
      8'd75:  s = 29'hffc6;
      8'd76:  s = 29'hffc7;
      8'd77:  s = 29'hff7f;
      8'd78:  s = 29'hff14;
      8'd79:  s = 29'hffb7;
      8'd80:  s = 29'hffb8;
      8'd81:  s = 29'hffb9;
      8'd82:  s = 29'hffad;
      8'd83:  s = 29'hffb4;
      8'd84:  s = 29'hffb5;
      8'd85:  s = 29'hffb6;
      8'd86:  s = 29'hffab;
      8'd87:  s = 29'hffb1;
      8'd88:  s = 29'hffb2;
      8'd89:  s = 29'hffb3;
      8'd90:  s = 29'hffb0;
      8'd91:  s = 29'hffae;
      8'd94:  s = 29'h3c;
      8'd95:  s = 29'hffc8;
      8'd96:  s = 29'hffc9;
      8'd97:  s = 29'h5c;
      8'd100: s = 29'hff21;
      8'd101: s = 29'hff2d;
      8'd102: s = 29'hff22;
      8'd104: s = 29'hff8d;
      8'd105: s = 29'hffe4;
      8'd106: s = 29'hffaf;
      8'd107: s = 29'hff15;
      8'd108: s = 29'hffea;
      8'd110: s = 29'hff50;
      8'd111: s = 29'hff52;
      8'd112: s = 29'hff55;
      8'd113: s = 29'hff51;
      8'd114: s = 29'hff53;
      8'd115: s = 29'hff57;
      8'd116: s = 29'hff54;
      8'd117: s = 29'hff56;
      8'd118: s = 29'hff63;
      8'd119: s = 29'hffff;
      8'd121: s = 29'h1008ff12;
      8'd122: s = 29'h1008ff11;
      8'd123: s = 29'h1008ff13;
      8'd124: s = 29'h1008ff2a;
      8'd125: s = 29'hffbd;
      8'd127: s = 29'hff13;
      8'd130: s = 29'hff31;
      8'd131: s = 29'hff34;
      8'd132: s = 29'hff2e;
      8'd133: s = 29'hffeb;
      8'd134: s = 29'hffec;
      8'd135: s = 29'hff67;
      8'd171: s = 29'h1008ff17;
      8'd172: s = 29'h1008ff14;
      8'd173: s = 29'h1008ff16;
      8'd174: s = 29'h1008ff15;
      default: s = 29'h0;
    endcase
    return s;
  endfunction

endpackage

[rtl/keycode_keysym_map_engine_unit.sv]
// Keycode to keysym map engine: table memory, scan sequencer and result register.
//
// Requests enter on the s_ channel: s_tuser is the kind (install, lookup,
// reverse lookup or allocate, restore default), s_tdata carries keycode,
// keysym and text_room. Each request gives one result on the m_ channel.
// One request is worked at a time; s_tready is high only while the
// sequencer is idle. The table is a single memory with one write port and
// one registered read port, and each kind of request works around that read port:
//   install: the table write at acceptance, then the result register
//   lookup: one memory read, then the result register
//   reverse lookup: a pipelined scan of one entry per cycle from
//     FIRST_SEARCH_CODE up, and on a miss a second scan from next-free up,
//     unless next-free is already past the end of the table
//   restore: a sweep rewriting the default map, then the result register
// After reset the same sweep runs with s_tready low and produces no result.
// The result register holds a finished result while m_tready is low; a new
// request is still taken then, and its result waits inside until the
// register frees.
module keycode_keysym_map_engine_unit
  import kkme_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH       = 256,
  parameter int unsigned FIRST_SEARCH_CODE = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // keycode[7:0], keysym[36:8], text_room[37], zero[39:38]
  input  logic [1:0]  s_tuser,   // kind[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata    // keysym_out[28:0], keycode_out[36:29], has_text[37],
                                 // text_byte[45:38], status[47:46]
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = AW + 1;
  localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_C  = CW'(TABLE_DEPTH);
  localparam logic [8:0]    DEPTH9   = 9'(TABLE_DEPTH);

  typedef enum logic [5:0] {
    S_INIT  = 6'b000001,
    S_IDLE  = 6'b000010,
    S_LOOK  = 6'b000100,
    S_SCAN1 = 6'b001000,
    S_SCAN2 = 6'b010000,
    S_EMIT  = 6'b100000
  } state_t;

  state_t           state;
  logic [CW-1:0]    scan_cnt;
  logic [8:0]       next_free;
  logic             init_emit;
  logic             rd_live;
  logic [AW-1:0]    rd_idx;
  logic [SYM_W-1:0] rd_data;
  logic [SYM_W-1:0] sym_q;
  logic             room_q;
  res_t             res;

  logic [SYM_W-1:0] mem [TABLE_DEPTH];

  // Input field unpacking
  logic [7:0]       in_code;
  logic [SYM_W-1:0] in_sym;
  logic             in_room;
  kind_t            in_kind;
  logic             code_ok;
  logic             accept;
  logic [1:0]       idle_st;
  assign in_code = s_tdata[7:0];
  assign in_sym  = s_tdata[36:8];
  assign in_room = s_tdata[37];
  assign in_kind = kind_t'(s_tuser);
  assign code_ok = {1'b0, in_code} < DEPTH9;
  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;

  // Status known at acceptance: bad keycodes are ignored
  always_comb begin
    idle_st = ST_DONE;
    if ((in_kind == K_INSTALL && !(code_ok && in_code != 8'd0)) ||
        (in_kind == K_LOOKUP && !code_ok)) begin
      idle_st = ST_IGNORED;
    end
  end

  // Memory port control
  logic             we;
  logic [AW-1:0]    wa;
  logic [SYM_W-1:0] wd;
  logic [AW-1:0]    rd_addr;
  logic             issue;
  logic [8:0]       lk_tr;

  assign issue = ((state == S_SCAN1) || (state == S_SCAN2)) && (scan_cnt < DEPTH_C);
  assign lk_tr = translate_sym(rd_data);

  always_comb begin
    we      = 1'b0;
    wa      = scan_cnt[AW-1:0];
    wd      = default_keysym(8'(scan_cnt[AW-1:0]));
    rd_addr = scan_cnt[AW-1:0];
    case (state)
      S_INIT: begin
        we = 1'b1;
      end
      S_IDLE: begin
        rd_addr = in_code[AW-1:0];
        if (accept && in_kind == K_INSTALL && code_ok && in_code != 8'd0) begin
          we = 1'b1;
          wa = in_code[AW-1:0];
          wd = in_sym;
        end
      end
      S_SCAN2: begin
        if (rd_live && rd_data == '0) begin
          we = 1'b1;
          wa = rd_idx;
          wd = sym_q;
        end
      end
      default: ;
    endcase
  end

  // Table memory with registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_data <= mem[rd_addr];
  end

  // Sequencer
  always_ff @(posedge clk) begin
    rd_idx <= scan_cnt[AW-1:0];
    if (rst) begin
      state     <= S_INIT;
      scan_cnt  <= '0;
      next_free <= 9'(FIRST_SEARCH_CODE);
      init_emit <= 1'b0;
      rd_live   <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      rd_live <= issue;
      if (m_tvalid && m_tready && state != S_EMIT) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        // default-map sweep, one entry a cycle
        S_INIT: begin
          scan_cnt <= scan_cnt + CW'(1);
          if (scan_cnt[AW-1:0] == LAST_IDX) begin
            next_free <= 9'(FIRST_SEARCH_CODE);
            res       <= '0;
            state     <= init_emit ? S_EMIT : S_IDLE;
          end
        end
        // take a request
        S_IDLE: begin
          if (s_tvalid) begin
            res    <= res_t'({idle_st, 46'd0});
            sym_q  <= in_sym;
            room_q <= in_room;
            case (in_kind)
              K_INSTALL: begin
                state <= S_EMIT;
              end
              K_LOOKUP: begin
                if (code_ok) begin
                  state <= S_LOOK;
                end else begin
                  state <= S_EMIT;
                end
              end
              K_REVERSE: begin
                if (in_sym == '0) begin
                  state <= S_EMIT;
                end else begin
                  scan_cnt <= CW'(FIRST_SEARCH_CODE);
                  state    <= S_SCAN1;
                end
              end
              default: begin
                scan_cnt  <= '0;
                init_emit <= 1'b1;
                state     <= S_INIT;
              end
            endcase
          end
        end
        // read data is back: keysym and text byte
        S_LOOK: begin
          res.keysym_out <= rd_data;
          if (room_q && lk_tr[8]) begin
            res.has_text  <= 1'b1;
            res.text_byte <= lk_tr[7:0];
          end
          state <= S_EMIT;
        end
        // search for a matching entry
        S_SCAN1: begin
          if (issue) begin
            scan_cnt <= scan_cnt + CW'(1);
          end
          if (rd_live && rd_data == sym_q) begin
            res.keycode_out <= 8'(rd_idx);
            state           <= S_EMIT;
          end else if (rd_live && rd_idx == LAST_IDX) begin
            if (next_free >= DEPTH9) begin
              res.status <= ST_EXHAUSTED;
              state      <= S_EMIT;
            end else begin
              scan_cnt <= CW'(next_free);
              state    <= S_SCAN2;
            end
          end
        end
        // search for an empty slot from next-free up
        S_SCAN2: begin
          if (issue) begin
            scan_cnt <= scan_cnt + CW'(1);
          end
          if (rd_live && rd_data == '0) begin
            res.keycode_out <= 8'(rd_idx);
            res.status      <= ST_ALLOC;
            next_free       <= 9'(rd_idx) + 9'd1;
            state           <= S_EMIT;
          end else if (rd_live && rd_idx == LAST_IDX) begin
            res.status <= ST_EXHAUSTED;
            state      <= S_EMIT;
          end
        end
        // hand the result to the output register once it is free
        S_EMIT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid  <= 1'b1;
            m_tdata   <= res;
            init_emit <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // A restore request starts the default sweep
  a_restore_sweep: assert property (@(posedge clk) disable iff (rst)
    (accept && in_kind == K_RESTORE) |=> (state == S_INIT && scan_cnt == '0))
    else $error("restore did not start the sweep");

  // next-free moves only on allocation, at the end of a sweep, or at reset
  a_next_free: assert property (@(posedge clk) disable iff (rst)
    !$stable(next_free) |->
      ($past(state) == S_SCAN2 || $past(state) == S_INIT || $past(rst)))
    else $error("next_free changed outside allocation or sweep");

  // A waiting result is not overwritten while the receiver stalls
  a_emit_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && m_tvalid && !m_tready) |=> (state == S_EMIT && $stable(m_tdata)))
    else $error("pending result lost under stall");

endmodule
